>>> src/sart_pkg.sv
// Shared types and constants for the sorted address range table.
package sart_pkg;

  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 32;
  localparam int GTAG_W  = 15;
  localparam int TAG_W   = 16;
  localparam int TOTAL_W = 7;

  // Request codes
  localparam logic [1:0] REQ_REGISTER   = 2'd0;
  localparam logic [1:0] REQ_UNREGISTER = 2'd1;
  localparam logic [1:0] REQ_LOOKUP     = 2'd2;

  // Cell commands
  localparam logic [2:0] CELL_HOLD   = 3'd0;
  localparam logic [2:0] CELL_INSERT = 3'd1;
  localparam logic [2:0] CELL_MARK   = 3'd2;
  localparam logic [2:0] CELL_SHIFT  = 3'd3;
  localparam logic [2:0] CELL_PROBE  = 3'd4;

  // Group store commands
  localparam logic [1:0] GRP_NONE    = 2'd0;
  localparam logic [1:0] GRP_CLAIM   = 2'd1;
  localparam logic [1:0] GRP_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [GTAG_W-1:0] group_tag;
    logic [GTAG_W-1:0] entry_index;
    logic [GTAG_W-1:0] group_count;
    logic              first_of_call;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [TAG_W-1:0]   found_tag;
    logic [TOTAL_W-1:0] entry_total;
    logic               dropped;
  } rsp_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic [2:0]       op;
    logic [TAG_W-1:0] new_tag;
    logic [TAG_W-1:0] span_lo;
    logic [TAG_W-1:0] span_hi;
  } cell_cmd_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [GTAG_W-1:0] base;
  } grp_cmd_t;

  typedef struct packed {
    logic found;
    logic has_free;
  } grp_stat_t;

endpackage

>>> src/sart_cell.sv
// One table cell: holds a range, compares against the broadcast key, moves with neighbors.
module sart_cell #(
  parameter int ADDR_BITS = 48,
  parameter int END_W     = 49
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sart_pkg::cell_cmd_t      cmd,
  input  logic [ADDR_BITS-1:0]     key,
  input  logic [END_W-1:0]         new_end,
  input  logic                     valid,
  input  logic [ADDR_BITS-1:0]     left_start,
  input  logic [END_W-1:0]         left_end,
  input  logic [sart_pkg::TAG_W-1:0] left_tag,
  input  logic                     left_gt,
  input  logic [ADDR_BITS-1:0]     right_start,
  input  logic [END_W-1:0]         right_end,
  input  logic [sart_pkg::TAG_W-1:0] right_tag,
  input  logic                     right_dead,
  input  logic                     right_gt,
  input  logic                     shift_in,
  output logic [ADDR_BITS-1:0]     cell_start,
  output logic [END_W-1:0]         cell_end,
  output logic [sart_pkg::TAG_W-1:0] cell_tag,
  output logic                     dead,
  output logic                     gt,
  output logic                     shift_out,
  output logic                     cand
);

  logic [END_W-1:0] key_ext;
  logic             in_span;

  // Empty cells count as above any key, so the boundary is a clean step
  assign gt        = !(valid && (cell_start <= key));
  assign shift_out = shift_in | dead;
  assign key_ext   = END_W'(key);
  assign in_span   = valid && (cell_tag >= cmd.span_lo) && (cell_tag < cmd.span_hi);

  // Payload: open a slot at the insert point, or close gaps during compaction
  always_ff @(posedge clk) begin
    case (cmd.op)
      sart_pkg::CELL_INSERT: begin
        if (left_gt) begin
          cell_start <= left_start;
          cell_end   <= left_end;
          cell_tag   <= left_tag;
        end else if (gt) begin
          cell_start <= key;
          cell_end   <= new_end;
          cell_tag   <= cmd.new_tag;
        end
      end
      sart_pkg::CELL_SHIFT: begin
        if (shift_out) begin
          cell_start <= right_start;
          cell_end   <= right_end;
          cell_tag   <= right_tag;
        end
      end
      default: begin
      end
    endcase
  end

  // Removal mark and lookup candidate flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dead <= 1'b0;
      cand <= 1'b0;
    end else begin
      case (cmd.op)
        sart_pkg::CELL_MARK:  dead <= in_span;
        sart_pkg::CELL_SHIFT: if (shift_out) dead <= right_dead;
        sart_pkg::CELL_PROBE: cand <= !gt && right_gt && (key_ext < cell_end);
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/sart_groups.sv
// Group base store: remembers registered bases and finds a free slot.
module sart_groups #(
  parameter int GROUPS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sart_pkg::grp_cmd_t   cmd,
  output sart_pkg::grp_stat_t  stat
);

  localparam int GI_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  logic [sart_pkg::GTAG_W-1:0] base_q [GROUPS];
  logic [GROUPS-1:0]           gvalid;
  logic [GROUPS-1:0]           match;
  logic [GI_W-1:0]             free_idx;

  // Compare the key against every slot and pick the lowest free one
  always_comb begin
    free_idx = '0;
    for (int g = GROUPS - 1; g >= 0; g--) begin
      match[g] = gvalid[g] && (base_q[g] == cmd.base);
      if (!gvalid[g]) free_idx = GI_W'(g);
    end
    stat.found    = |match;
    stat.has_free = !(&gvalid);
  end

  always_ff @(posedge clk) begin
    if (cmd.op == sart_pkg::GRP_CLAIM) base_q[free_idx] <= cmd.base;
  end

  // Claim sets one slot, release forgets every matching one
  always_ff @(posedge clk) begin
    if (rst) begin
      gvalid <= '0;
    end else begin
      case (cmd.op)
        sart_pkg::GRP_CLAIM:   gvalid[free_idx] <= 1'b1;
        sart_pkg::GRP_RELEASE: gvalid <= gvalid & ~match;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/sorted_address_range_table_top.sv
// Sequence: an accepted item is decoded, then a register item passes the insert state,
// a lookup the probe capture state and an unregister the compaction state; a zero-base
// unregister or unknown type goes straight to the done state, which loads the result.
// A new item is accepted only once the result is loaded; compaction of an unregister
// removes one gap per cycle along the row. Reset: synchronous, clears the range count,
// group valid bits and call state; stored ranges and bases are not cleared.
module sorted_address_range_table_top #(
  parameter int ENTRIES   = 64,
  parameter int GROUPS    = 32,
  parameter int ADDR_BITS = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sart_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output sart_pkg::rsp_t  rsp
);

  localparam int END_W = ((ADDR_BITS > sart_pkg::LEN_W) ? ADDR_BITS : sart_pkg::LEN_W) + 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_LK   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]             state;
  sart_pkg::req_t         cur;
  logic [CNT_W-1:0]       count;
  logic                   skipping;
  logic                   take;
  logic                   drop;
  logic                   hit_q;
  logic [sart_pkg::TAG_W-1:0] tag_q;

  logic [ADDR_BITS+sart_pkg::ADDR_W-1:0] addr_wide;
  logic [ADDR_BITS-1:0]   key;
  logic [END_W-1:0]       new_end;
  logic                   addr_nz;
  logic                   base_nz;
  logic [sart_pkg::TAG_W-1:0] base16;
  logic [CNT_W+sart_pkg::TOTAL_W-1:0] total_wide;

  sart_pkg::cell_cmd_t    ccmd;
  sart_pkg::grp_cmd_t     gcmd;
  sart_pkg::grp_stat_t    gstat;

  logic [ADDR_BITS-1:0]   c_start [ENTRIES];
  logic [END_W-1:0]       c_end   [ENTRIES];
  logic [sart_pkg::TAG_W-1:0] c_tag [ENTRIES];
  logic [ENTRIES-1:0]     c_dead;
  logic [ENTRIES-1:0]     c_gt;
  logic [ENTRIES-1:0]     c_shift;
  logic [ENTRIES-1:0]     c_cand;
  logic [ENTRIES-1:0]     c_valid;

  logic                   any_cand;
  logic [sart_pkg::TAG_W-1:0] cand_tag;

  // Mask the address to the table width and form the range end
  assign addr_wide = {{ADDR_BITS{1'b0}}, cur.address};
  assign key       = addr_wide[ADDR_BITS-1:0];
  assign new_end   = END_W'(key) + END_W'(cur.length);
  assign addr_nz   = |key;
  assign base_nz   = |cur.group_tag;
  assign base16    = sart_pkg::TAG_W'(cur.group_tag);
  assign total_wide = {{sart_pkg::TOTAL_W{1'b0}}, count};

  assign req_ready = (state == S_IDLE);

  // Broadcast commands for this cycle
  always_comb begin
    ccmd.op      = sart_pkg::CELL_HOLD;
    ccmd.new_tag = base16 + sart_pkg::TAG_W'(cur.entry_index);
    ccmd.span_lo = base16;
    ccmd.span_hi = base16 + sart_pkg::TAG_W'(cur.group_count);
    gcmd.op      = sart_pkg::GRP_NONE;
    gcmd.base    = cur.group_tag;
    case (state)
      S_DEC: begin
        case (cur.req_type)
          sart_pkg::REQ_REGISTER: begin
            if (cur.first_of_call && base_nz && !gstat.found && gstat.has_free)
              gcmd.op = sart_pkg::GRP_CLAIM;
          end
          sart_pkg::REQ_UNREGISTER: begin
            if (base_nz) begin
              gcmd.op = sart_pkg::GRP_RELEASE;
              ccmd.op = sart_pkg::CELL_MARK;
            end
          end
          sart_pkg::REQ_LOOKUP: ccmd.op = sart_pkg::CELL_PROBE;
          default: begin
          end
        endcase
      end
      S_INS: begin
        if (take && (count != CNT_W'(ENTRIES))) ccmd.op = sart_pkg::CELL_INSERT;
      end
      S_CMP: begin
        if (c_shift[ENTRIES-1]) ccmd.op = sart_pkg::CELL_SHIFT;
      end
      default: begin
      end
    endcase
  end

  // Row of cells; each sees only its two neighbors
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic [ADDR_BITS-1:0]       l_start;
    logic [END_W-1:0]           l_end;
    logic [sart_pkg::TAG_W-1:0] l_tag;
    logic                       l_gt;
    logic [ADDR_BITS-1:0]       r_start;
    logic [END_W-1:0]           r_end;
    logic [sart_pkg::TAG_W-1:0] r_tag;
    logic                       r_dead;
    logic                       r_gt;
    logic                       s_in;

    assign c_valid[i] = (IDX < count);

    if (i == 0) begin : g_first
      assign l_start = '0;
      assign l_end   = '0;
      assign l_tag   = '0;
      assign l_gt    = 1'b0;
      assign s_in    = 1'b0;
    end else begin : g_mid_l
      assign l_start = c_start[i-1];
      assign l_end   = c_end[i-1];
      assign l_tag   = c_tag[i-1];
      assign l_gt    = c_gt[i-1];
      assign s_in    = c_shift[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign r_start = '0;
      assign r_end   = '0;
      assign r_tag   = '0;
      assign r_dead  = 1'b0;
      assign r_gt    = 1'b1;
    end else begin : g_mid_r
      assign r_start = c_start[i+1];
      assign r_end   = c_end[i+1];
      assign r_tag   = c_tag[i+1];
      assign r_dead  = c_dead[i+1];
      assign r_gt    = c_gt[i+1];
    end

    sart_cell #(
      .ADDR_BITS (ADDR_BITS),
      .END_W     (END_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (ccmd),
      .key         (key),
      .new_end     (new_end),
      .valid       (c_valid[i]),
      .left_start  (l_start),
      .left_end    (l_end),
      .left_tag    (l_tag),
      .left_gt     (l_gt),
      .right_start (r_start),
      .right_end   (r_end),
      .right_tag   (r_tag),
      .right_dead  (r_dead),
      .right_gt    (r_gt),
      .shift_in    (s_in),
      .cell_start  (c_start[i]),
      .cell_end    (c_end[i]),
      .cell_tag    (c_tag[i]),
      .dead        (c_dead[i]),
      .gt          (c_gt[i]),
      .shift_out   (c_shift[i]),
      .cand        (c_cand[i])
    );
  end

  sart_groups #(
    .GROUPS (GROUPS)
  ) u_groups (
    .clk  (clk),
    .rst  (rst),
    .cmd  (gcmd),
    .stat (gstat)
  );

  // Collect the single lookup candidate
  always_comb begin
    any_cand = |c_cand;
    cand_tag = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (c_cand[i]) cand_tag = cand_tag | c_tag[i];
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) cur <= req;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      skipping  <= 1'b0;
      take      <= 1'b0;
      drop      <= 1'b0;
      hit_q     <= 1'b0;
      tag_q     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            take  <= 1'b0;
            drop  <= 1'b0;
            hit_q <= 1'b0;
            tag_q <= '0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          case (cur.req_type)
            sart_pkg::REQ_REGISTER: begin
              if (cur.first_of_call) begin
                if (!base_nz || gstat.found) begin
                  skipping <= 1'b1;
                end else if (!gstat.has_free) begin
                  skipping <= 1'b1;
                  drop     <= 1'b1;
                end else begin
                  skipping <= 1'b0;
                  take     <= addr_nz && (|cur.length);
                end
              end else begin
                take <= !skipping && base_nz && addr_nz && (|cur.length);
              end
              state <= S_INS;
            end
            sart_pkg::REQ_UNREGISTER: state <= base_nz ? S_CMP : S_DONE;
            sart_pkg::REQ_LOOKUP:     state <= S_LK;
            default:                  state <= S_DONE;
          endcase
        end
        S_INS: begin
          if (take) begin
            if (count == CNT_W'(ENTRIES)) drop <= 1'b1;
            else count <= count + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_CMP: begin
          // Drop one gap per cycle until no marked range remains
          if (c_shift[ENTRIES-1]) count <= count - CNT_W'(1);
          else state <= S_DONE;
        end
        S_LK: begin
          hit_q <= addr_nz && any_cand;
          tag_q <= (addr_nz && any_cand) ? cand_tag : '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Raise result valid when a result is loaded, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!rsp_valid || rsp_ready)) begin
      rsp.hit         <= hit_q;
      rsp.found_tag   <= tag_q;
      rsp.entry_total <= total_wide[sart_pkg::TOTAL_W-1:0];
      rsp.dropped     <= drop;
    end
  end

endmodule

>>> src/sart_checker.sv
// Port-level checks for the sorted address range table, bound to the top level.
module sart_checker #(
  parameter int ENTRIES = 64
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input sart_pkg::rsp_t rsp
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // One item in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a second item while busy");

  // Count never exceeds the table size
  a_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.entry_total <= ENTRIES))
    else $error("entry total above table size");

  // A miss reports no tag
  a_miss_tag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |-> (rsp.found_tag == '0))
    else $error("tag reported without a hit");

  // Hit and drop belong to different request kinds
  a_hit_drop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.hit && rsp.dropped))
    else $error("hit and dropped both set");

endmodule

bind sorted_address_range_table_top sart_checker #(
  .ENTRIES (ENTRIES)
) u_sart_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
